// ===== design/mkrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mkrs_pkg
// Shared types and constants for the multi key rank sorter: payload structs,
// sort mode codes, controller states and controller/datapath command bundles.
// ----------------------------------------------------------------------------
package mkrs_pkg;

    localparam int MAX_RECORDS = 32;
    localparam int NAME_CHARS  = 16;
    localparam int NAME_BYTES  = 16;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int KEY_W       = 8 * NAME_BYTES;
    localparam int OUT_W       = 5;
    localparam int MODE_W      = 3;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE    = 3'd0,
        MODE_ID      = 3'd1,
        MODE_NAME    = 3'd2,
        MODE_LOAD    = 3'd3,
        MODE_RUNTIME = 3'd4,
        MODE_STACK   = 3'd5,
        MODE_HEAP    = 3'd6
    } t_sort_mode;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_RANK,
        ST_DRAIN,
        ST_EMIT_RD,
        ST_EMIT_SEND
    } t_ctl_state;

    typedef struct packed {
        logic [15:0] task_id;
        logic [63:0] name_low;
        logic [63:0] name_high;
        logic [9:0]  cpu_load;
        logic [31:0] run_time;
        logic [15:0] stack_free;
        logic [31:0] heap_used;
        logic        last_record;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] source_index;
        logic [OUT_W-1:0] position;
        logic             last_result;
    } t_out_item;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic             cmp_go;
        logic [IDX_W-1:0] cmp_i;
        logic [IDX_W-1:0] cmp_j;
        logic             cmp_last;
        logic [IDX_W-1:0] rank_top;
        logic             out_rd;
        logic [IDX_W-1:0] out_addr;
        logic             out_last;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
    } t_dp_stat;

endpackage

// ===== design/multi_key_rank_sorter_core.sv =====
// ----------------------------------------------------------------------------
// multi_key_rank_sorter_core
// Loads task records until one is flagged last, ranks them by counting
// comparisons under the selected key, then returns the load index at each
// sorted position, position 0 first.
//
//   channel   direction   signals                                  payload
//   request   in          i_req_valid / o_req_ready / i_req_data   t_in_item
//   result    out         o_rsp_valid / i_rsp_ready / o_rsp_data   t_out_item
//   config    in          i_cfg_valid / o_cfg_ready / i_cfg_data   sort mode
//
// a request is accepted while the core is loading; records past capacity are dropped
// a run of n records ranks in n*n compares, one compare per cycle through a
// record memory read at two addresses, then the compare pipeline drains
// each result then needs a rank table read followed by the result handshake
// synchronous active-low reset clears the record count and sets mode to none
// requests are held off from the last record until the final result is taken
// ----------------------------------------------------------------------------
module multi_key_rank_sorter_core import mkrs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  t_in_item          i_req_data,
    output logic              o_rsp_valid,
    input  logic              i_rsp_ready,
    output t_out_item         o_rsp_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MODE_W-1:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    assign o_cfg_ready = 1'b1;

    mkrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_last  (i_req_data.last_record),
        .i_rsp_ready (i_rsp_ready),
        .i_stat      (w_stat),
        .o_req_ready (o_req_ready),
        .o_rsp_valid (o_rsp_valid),
        .o_cmd       (w_cmd)
    );

    mkrs_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req_data  (i_req_data),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_stat      (w_stat),
        .o_rsp_data  (o_rsp_data)
    );

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid |-> !o_req_ready)
        else $error("result offered while requests are taken");

    a_last_stops_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && o_req_ready && i_req_data.last_record) |=> !o_req_ready)
        else $error("request taken right after last record");

    a_run_end_reopens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_ready && o_rsp_data.last_result) |=> o_req_ready)
        else $error("load not resumed after final result");

    a_position_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp_valid && i_rsp_ready && !o_rsp_data.last_result) |-> ##2
        (o_rsp_valid && o_rsp_data.position == $past(o_rsp_data.position, 2) + 5'd1))
        else $error("result positions out of sequence");

endmodule

// ===== design/mkrs_datapath.sv =====
// ----------------------------------------------------------------------------
// mkrs_datapath
// Record memory, three stage compare pipeline with win counter, rank table
// and the result register.
// ----------------------------------------------------------------------------
module mkrs_datapath import mkrs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  t_in_item            i_req_data,
    input  logic                i_cfg_we,
    input  logic [MODE_W-1:0]   i_cfg_data,
    output t_dp_stat            o_stat,
    output t_out_item           o_rsp_data
);

    typedef struct packed {
        logic [15:0]      id;
        logic [KEY_W-1:0] name_key;
        logic [9:0]       load;
        logic [31:0]      run;
        logic [15:0]      stack;
        logic [31:0]      heap;
    } t_rec;

    // folded name, first char in the top byte, zeroed from the terminator on
    function automatic logic [KEY_W-1:0] name_key(input logic [63:0] lo,
                                                  input logic [63:0] hi);
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] raw;
        logic [7:0]       ch;
        logic             ended;
        key   = '0;
        raw   = {hi, lo};
        ended = 1'b0;
        for (int c = 0; c < NAME_BYTES; c++) begin
            ch = raw[8*c +: 8];
            if (ch == 8'h00) ended = 1'b1;
            if (ch >= 8'h41 && ch <= 8'h5A) ch = ch + 8'h20;
            if (!ended && c < NAME_CHARS) key[KEY_W-8-8*c +: 8] = ch;
        end
        return key;
    endfunction

    function automatic logic [KEY_W-1:0] sel_key(input t_rec rec,
                                                 input logic [MODE_W-1:0] mode);
        logic [KEY_W-1:0] key;
        case (mode)
            MODE_ID:      key = {{(KEY_W-16){1'b0}}, rec.id};
            MODE_NAME:    key = rec.name_key;
            // descending keys are inverted so one ascending compare serves all
            MODE_LOAD:    key = {{(KEY_W-10){1'b0}}, ~rec.load};
            MODE_RUNTIME: key = {{(KEY_W-32){1'b0}}, ~rec.run};
            MODE_STACK:   key = {{(KEY_W-16){1'b0}}, ~rec.stack};
            MODE_HEAP:    key = {{(KEY_W-32){1'b0}}, ~rec.heap};
            default:      key = '0;
        endcase
        return key;
    endfunction

    t_rec                r_rec_mem [MAX_RECORDS];
    logic [IDX_W-1:0]    r_pos_mem [MAX_RECORDS];
    logic [MODE_W-1:0]   r_mode;

    t_rec                w_rec;

    // stage 1: read data
    logic                r_v1;
    t_rec                r_rd_a;
    t_rec                r_rd_b;
    logic [IDX_W-1:0]    r_i1;
    logic [IDX_W-1:0]    r_j1;
    logic                r_last1;

    // stage 2: selected keys
    logic                r_v2;
    logic [KEY_W-1:0]    r_ka;
    logic [KEY_W-1:0]    r_kb;
    logic [15:0]         r_ida;
    logic [15:0]         r_idb;
    logic                r_none2;
    logic [IDX_W-1:0]    r_i2;
    logic [IDX_W-1:0]    r_j2;
    logic                r_last2;

    logic [CNT_W-1:0]    r_wins;
    logic [CNT_W-1:0]    w_total;
    logic [IDX_W-1:0]    w_pos;
    logic                w_win;
    logic                w_none;
    t_out_item           r_out;

    always_comb begin
        w_rec.id       = i_req_data.task_id;
        w_rec.name_key = name_key(i_req_data.name_low, i_req_data.name_high);
        w_rec.load     = i_req_data.cpu_load;
        w_rec.run      = i_req_data.run_time;
        w_rec.stack    = i_req_data.stack_free;
        w_rec.heap     = i_req_data.heap_used;
    end

    always_comb begin
        case (r_mode)
            MODE_ID, MODE_NAME, MODE_LOAD, MODE_RUNTIME, MODE_STACK, MODE_HEAP: begin
                w_none = 1'b0;
            end
            default: begin
                w_none = 1'b1;
            end
        endcase
    end

    // record i beats record j: key, then id, then load order; with no valid mode, later load wins
    always_comb begin
        if (r_none2) begin
            w_win = r_j2 < r_i2;
        end else begin
            w_win = (r_ka < r_kb)
                 || (r_ka == r_kb && (r_ida < r_idb || (r_ida == r_idb && r_i2 < r_j2)));
        end
        w_total = r_wins + CNT_W'(w_win);
        w_pos   = i_cmd.rank_top - w_total[IDX_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_rec_mem[i_cmd.wr_addr] <= w_rec;
        end
        if (i_cmd.cmp_go) begin
            r_rd_a <= r_rec_mem[i_cmd.cmp_i];
            r_rd_b <= r_rec_mem[i_cmd.cmp_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && r_last2) begin
            r_pos_mem[w_pos] <= r_i2;
        end
        if (i_cmd.out_rd) begin
            r_out.source_index <= OUT_W'(r_pos_mem[i_cmd.out_addr]);
            r_out.position     <= OUT_W'(i_cmd.out_addr);
            r_out.last_result  <= i_cmd.out_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1    <= i_cmd.cmp_i;
        r_j1    <= i_cmd.cmp_j;
        r_last1 <= i_cmd.cmp_last;
        r_ka    <= sel_key(r_rd_a, r_mode);
        r_kb    <= sel_key(r_rd_b, r_mode);
        r_ida   <= r_rd_a.id;
        r_idb   <= r_rd_b.id;
        r_none2 <= w_none;
        r_i2    <= r_i1;
        r_j2    <= r_j1;
        r_last2 <= r_last1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_wins <= '0;
            r_mode <= MODE_NONE;
        end else begin
            r_v1 <= i_cmd.cmp_go;
            r_v2 <= r_v1;
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            if (r_v2) begin
                r_wins <= r_last2 ? '0 : w_total;
            end
        end
    end

    assign o_stat.pipe_busy = r_v1 | r_v2;
    assign o_rsp_data       = r_out;

endmodule

// ===== design/mkrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mkrs_ctrl
// Sequencer: load count, pair loop over (i, j), pipeline drain and the
// result read-out loop.
// ----------------------------------------------------------------------------
module mkrs_ctrl import mkrs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_req_valid,
    input  logic      i_req_last,
    input  logic      i_rsp_ready,
    input  t_dp_stat  i_stat,
    output logic      o_req_ready,
    output logic      o_rsp_valid,
    output t_dp_cmd   o_cmd
);

    t_ctl_state       r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [IDX_W-1:0] r_top, n_top;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_p, n_p;

    logic             w_acc;
    logic             w_room;
    logic [CNT_W-1:0] w_cnt_inc;

    assign w_acc     = i_req_valid && (r_state == ST_LOAD);
    assign w_room    = r_count < CNT_W'(MAX_RECORDS);
    assign w_cnt_inc = r_count + CNT_W'(w_room);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_LOAD: begin
                if (w_acc && i_req_last) n_state = ST_RANK;
            end
            ST_RANK: begin
                if (r_i == r_top && r_j == r_top) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                if (!i_stat.pipe_busy) n_state = ST_EMIT_RD;
            end
            ST_EMIT_RD: begin
                n_state = ST_EMIT_SEND;
            end
            ST_EMIT_SEND: begin
                if (i_rsp_ready) n_state = (r_p == r_top) ? ST_LOAD : ST_EMIT_RD;
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        n_i     = r_i;
        n_j     = r_j;
        n_p     = r_p;
        case (r_state)
            ST_LOAD: begin
                if (w_acc) begin
                    n_count = w_cnt_inc;
                    if (i_req_last) begin
                        n_count = '0;
                        n_top   = IDX_W'(w_cnt_inc - CNT_W'(1));
                        n_i     = '0;
                        n_j     = '0;
                        n_p     = '0;
                    end
                end
            end
            ST_RANK: begin
                if (r_j == r_top) begin
                    n_j = '0;
                    n_i = r_i + IDX_W'(1);
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            ST_EMIT_SEND: begin
                if (i_rsp_ready) n_p = r_p + IDX_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_req_ready    = (r_state == ST_LOAD);
        o_rsp_valid    = (r_state == ST_EMIT_SEND);
        o_cmd.wr_en    = w_acc && w_room;
        o_cmd.wr_addr  = r_count[IDX_W-1:0];
        o_cmd.cmp_go   = (r_state == ST_RANK);
        o_cmd.cmp_i    = r_i;
        o_cmd.cmp_j    = r_j;
        o_cmd.cmp_last = (r_j == r_top);
        o_cmd.rank_top = r_top;
        o_cmd.out_rd   = (r_state == ST_EMIT_RD);
        o_cmd.out_addr = r_p;
        o_cmd.out_last = (r_p == r_top);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_count <= '0;
            r_top   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_p     <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
            r_i     <= n_i;
            r_j     <= n_j;
            r_p     <= n_p;
        end
    end

endmodule

// ===== verif/mkrs_checker.sv =====
// ----------------------------------------------------------------------------
// mkrs_checker
// Watches the request, result and config channels of the rank sorter. Keeps
// its own copy of the record set and sort mode, ranks each completed set by
// counting comparisons (reverse load order for unused modes), and compares
// every returned result, field by field, with the oldest predicted position.
// ----------------------------------------------------------------------------
module mkrs_checker import mkrs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  logic              i_req_ready,
    input  t_in_item          i_req_data,
    input  logic              i_rsp_valid,
    input  logic              i_rsp_ready,
    input  t_out_item         i_rsp_data,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [MODE_W-1:0] i_cfg_data,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_checked
);

    logic [15:0]       rec_id      [MAX_RECORDS];
    logic [63:0]       rec_name_lo [MAX_RECORDS];
    logic [63:0]       rec_name_hi [MAX_RECORDS];
    logic [9:0]        rec_load    [MAX_RECORDS];
    logic [31:0]       rec_runtime [MAX_RECORDS];
    logic [15:0]       rec_stack   [MAX_RECORDS];
    logic [31:0]       rec_heap    [MAX_RECORDS];
    int                rec_count;
    logic [MODE_W-1:0] cur_mode;
    t_out_item         expected_order[$];

    // name byte with upper case folded to lower
    function automatic logic [7:0] folded_char(int r, int c);
        logic [63:0] w;
        logic [7:0]  ch;
        w  = (c < 8) ? rec_name_lo[r] : rec_name_hi[r];
        ch = w[(c % 8) * 8 +: 8];
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            ch = ch + 8'h20;
        end
        return ch;
    endfunction

    function automatic bit id_ahead(int x, int y);
        if (rec_id[x] != rec_id[y]) begin
            return rec_id[x] < rec_id[y];
        end
        return x < y;
    endfunction

    function automatic bit name_ahead(int x, int y);
        logic [7:0] a;
        logic [7:0] b;
        for (int c = 0; c < NAME_CHARS; c++) begin
            a = folded_char(x, c);
            b = folded_char(y, c);
            if (a == 8'h00 && b == 8'h00) begin
                break;
            end
            if (b == 8'h00) begin
                return 1'b0;
            end
            if (a == 8'h00) begin
                return 1'b1;
            end
            if (a != b) begin
                return a < b;
            end
        end
        return id_ahead(x, y);
    endfunction

    // numeric keys sort descending
    function automatic bit key_ahead(logic [31:0] a, logic [31:0] b, int x, int y);
        if (a != b) begin
            return a > b;
        end
        return id_ahead(x, y);
    endfunction

    function automatic bit ranks_ahead(int x, int y);
        case (cur_mode)
            MODE_ID:      return id_ahead(x, y);
            MODE_NAME:    return name_ahead(x, y);
            MODE_LOAD:    return key_ahead(32'(rec_load[x]), 32'(rec_load[y]), x, y);
            MODE_RUNTIME: return key_ahead(rec_runtime[x], rec_runtime[y], x, y);
            MODE_STACK:   return key_ahead(32'(rec_stack[x]), 32'(rec_stack[y]), x, y);
            MODE_HEAP:    return key_ahead(rec_heap[x], rec_heap[y], x, y);
            default:      return 1'b0;
        endcase
    endfunction

    task automatic rank_set();
        int        slot_src [MAX_RECORDS];
        int        wins;
        int        pos;
        t_out_item e;
        for (int i = 0; i < rec_count; i++) begin
            pos = rec_count - 1 - i;
            if (cur_mode >= MODE_ID && cur_mode <= MODE_HEAP) begin
                wins = 0;
                for (int j = 0; j < rec_count; j++) begin
                    if (j != i && ranks_ahead(i, j)) begin
                        wins++;
                    end
                end
                pos = rec_count - 1 - wins;
            end
            slot_src[pos] = i;
        end
        for (int p = 0; p < rec_count; p++) begin
            e.source_index = slot_src[p][OUT_W-1:0];
            e.position     = p[OUT_W-1:0];
            e.last_result  = (p == rec_count - 1);
            expected_order.push_back(e);
        end
        rec_count = 0;
    endtask

    task automatic store_record(t_in_item it);
        if (rec_count < MAX_RECORDS) begin
            rec_id[rec_count]      = it.task_id;
            rec_name_lo[rec_count] = it.name_low;
            rec_name_hi[rec_count] = it.name_high;
            rec_load[rec_count]    = it.cpu_load;
            rec_runtime[rec_count] = it.run_time;
            rec_stack[rec_count]   = it.stack_free;
            rec_heap[rec_count]    = it.heap_used;
            rec_count++;
        end
        if (it.last_record) begin
            rank_set();
        end
    endtask

    task automatic check_result(t_out_item got);
        t_out_item want;
        if (expected_order.size() == 0) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("unexpected result: src %0d pos %0d last %0b",
                         got.source_index, got.position, got.last_result);
            end
            return;
        end
        want = expected_order.pop_front();
        o_checked++;
        if (got.source_index != want.source_index || got.position != want.position ||
            got.last_result != want.last_result) begin
            o_fail_count++;
            if (o_fail_count <= 10) begin
                $display("result mismatch: expected src %0d pos %0d last %0b, got src %0d pos %0d last %0b",
                         want.source_index, want.position, want.last_result,
                         got.source_index, got.position, got.last_result);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rec_count    = 0;
            cur_mode     = MODE_NONE;
            expected_order.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                cur_mode = i_cfg_data;
            end
            if (i_rsp_valid && i_rsp_ready) begin
                check_result(i_rsp_data);
            end
            if (i_req_valid && i_req_ready) begin
                store_record(i_req_data);
            end
        end
        o_pending = expected_order.size();
    end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives record sets into the multi key rank sorter under every sort mode,
// with random request gaps and result stalls, and reports the verdict from
// the checker's failure count. A directed pass covers field extremes, name
// folding, prefixes and ties; a random pass follows with mostly small sets,
// a few full ones and a few that overflow capacity.
// ----------------------------------------------------------------------------
module tb_top import mkrs_pkg::*; ();

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 270;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_req_valid;
    logic              o_req_ready;
    t_in_item          i_req_data;
    logic              o_rsp_valid;
    logic              i_rsp_ready;
    t_out_item         o_rsp_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [MODE_W-1:0] i_cfg_data;

    int fail_count;
    int pending;
    int checked;
    int cycle_count   = 0;
    int records_sent  = 0;
    int sets_sent     = 0;
    int rsp_hold      = 0;
    bit rsp_stalls_on = 1'b1;

    always #5 i_clk = ~i_clk;

    multi_key_rank_sorter_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req_data  (i_req_data),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp_data  (o_rsp_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    mkrs_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .i_req_ready  (o_req_ready),
        .i_req_data   (i_req_data),
        .i_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .i_rsp_data   (o_rsp_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side backpressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
            rsp_hold = 0;
        end else if (rsp_hold > 0) begin
            i_rsp_ready <= 1'b0;
            rsp_hold--;
        end else if (rsp_stalls_on && $urandom_range(0, 99) < 20) begin
            i_rsp_ready <= 1'b0;
            rsp_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                    : $urandom_range(8, 40);
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    function automatic t_in_item task_record(logic [15:0] id, logic [63:0] nm_lo,
                                             logic [63:0] nm_hi, logic [9:0] load,
                                             logic [31:0] rt, logic [15:0] stk,
                                             logic [31:0] heap, bit is_last);
        t_in_item it;
        it.task_id     = id;
        it.name_low    = nm_lo;
        it.name_high   = nm_hi;
        it.cpu_load    = load;
        it.run_time    = rt;
        it.stack_free  = stk;
        it.heap_used   = heap;
        it.last_record = is_last;
        return it;
    endfunction

    // random garbage stays behind the terminator
    function automatic logic [127:0] make_name();
        logic [127:0] nm;
        int           style;
        int           len;
        nm    = {$urandom, $urandom, $urandom, $urandom};
        style = $urandom_range(0, 9);
        if (style == 0) begin
            return '0;
        end else if (style == 1) begin
            return nm;
        end
        len = $urandom_range(0, NAME_CHARS);
        for (int c = 0; c < NAME_CHARS; c++) begin
            if (c < len) begin
                if (style < 7) begin
                    // tiny alphabet so prefixes and case-folded ties show up
                    nm[c*8 +: 8] = ($urandom_range(0, 1) ? 8'h41 : 8'h61) +
                                   8'($urandom_range(0, 1));
                end else begin
                    nm[c*8 +: 8] = 8'($urandom_range(8'h20, 8'h7E));
                end
            end else if (c == len) begin
                nm[c*8 +: 8] = 8'h00;
            end
        end
        return nm;
    endfunction

    function automatic logic [31:0] key_value(logic [31:0] top);
        if ($urandom_range(0, 2) == 0) begin
            return $urandom_range(0, 2);
        end
        return $urandom_range(0, top);
    endfunction

    function automatic t_in_item make_record(bit is_last);
        t_in_item it;
        it.task_id = ($urandom_range(0, 99) < 15) ? 16'($urandom_range(0, 3))
                                                  : 16'($urandom_range(0, 16'hFFFF));
        {it.name_high, it.name_low} = make_name();
        it.cpu_load    = 10'(key_value(1000));
        it.run_time    = key_value(32'hFFFF_FFFF);
        it.stack_free  = 16'(key_value(16'hFFFF));
        it.heap_used   = key_value(32'hFFFF_FFFF);
        it.last_record = is_last;
        return it;
    endfunction

    task automatic send_record(t_in_item it);
        i_req_valid <= 1'b1;
        i_req_data  <= it;
        @(posedge i_clk);
        while (!o_req_ready) begin
            @(posedge i_clk);
        end
        records_sent++;
    endtask

    task automatic req_pause(int cycles);
        if (cycles > 0) begin
            i_req_valid <= 1'b0;
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    // sender holds off until every predicted result has come back
    task automatic wait_drained();
        i_req_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_mode(logic [MODE_W-1:0] mode);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mode;
        @(posedge i_clk);
        while (!o_cfg_ready) begin
            @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random_set(int size, bit no_gaps);
        for (int k = 0; k < size; k++) begin
            send_record(make_record(k == size - 1));
            if (!no_gaps) begin
                req_pause(idle_gap());
            end
        end
        sets_sent++;
    endtask

    task automatic send_tie_set();
        // same folded name, prefix, key ties and a full tie on id
        send_record(task_record(16'd10, 64'h6261, 64'h0, 10'd1000, 32'hFFFF_FFFF,
                                16'hFFFF, 32'hFFFF_FFFF, 1'b0));
        req_pause(idle_gap());
        send_record(task_record(16'd3, 64'h4241, 64'hDEAD_BEEF_0BAD_F00D, 10'd0, 32'd0,
                                16'd0, 32'd0, 1'b0));
        req_pause(idle_gap());
        send_record(task_record(16'd10, 64'h636261, 64'h0, 10'd1000, 32'hFFFF_FFFF,
                                16'hFFFF, 32'hFFFF_FFFF, 1'b1));
        sets_sent++;
    endtask

    initial begin
        int target;
        int size;
        int r;
        i_rst_n     <= 1'b0;
        i_req_valid <= 1'b0;
        i_req_data  <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= MODE_NONE;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // reset mode: reverse load order, field extremes
        send_record(task_record(16'd0, 64'h0, 64'h0, 10'd0, 32'd0, 16'd0, 32'd0, 1'b0));
        send_record(task_record(16'hFFFF, '1, '1, 10'd1000, 32'hFFFF_FFFF, 16'hFFFF,
                                32'hFFFF_FFFF, 1'b0));
        send_record(task_record(16'h5A5A, 64'h0068_6374_6177, 64'h0, 10'd512,
                                32'h8000_0000, 16'h8000, 32'h0000_0001, 1'b1));
        sets_sent++;
        wait_drained();

        for (int m = MODE_ID; m <= MODE_HEAP; m++) begin
            write_mode(m[MODE_W-1:0]);
            send_tie_set();
            wait_drained();
        end

        // unused mode code falls back to reverse load order
        write_mode(3'd7);
        send_record(task_record(16'd1, 64'h61, 64'h0, 10'd5, 32'd5, 16'd5, 32'd5, 1'b0));
        send_record(task_record(16'd0, 64'h62, 64'h0, 10'd9, 32'd9, 16'd9, 32'd9, 1'b1));
        sets_sent++;
        wait_drained();

        // full capacity, then two dropped records with last on the dropped one
        write_mode(MODE_HEAP);
        send_random_set(MAX_RECORDS + 2, 1'b1);

        target = records_sent + RANDOM_ITEMS;
        while (records_sent < target) begin
            if ($urandom_range(0, 99) < 35) begin
                wait_drained();
                write_mode(3'($urandom_range(0, 7)));
            end
            r = $urandom_range(0, 99);
            if (r < 60) begin
                size = $urandom_range(1, 4);
            end else if (r < 90) begin
                size = $urandom_range(5, 10);
            end else if (r < 97) begin
                size = $urandom_range(11, MAX_RECORDS);
            end else begin
                size = $urandom_range(MAX_RECORDS + 1, MAX_RECORDS + 4);
            end
            rsp_stalls_on = ($urandom_range(0, 3) != 0);
            send_random_set(size, $urandom_range(0, 3) == 0);
        end

        wait_drained();
        repeat (20) @(posedge i_clk);

        $display("covered %0d records in %0d sets, all eight mode codes, capacity overflow",
                 records_sent, sets_sent);
        $display("%0d sorted positions compared against prediction", checked);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
